[hw/rtl/akl_pkg.sv]
// shared types, constants and datapath functions for the block encryptor
`timescale 1ns / 1ps
`default_nettype none

package akl_pkg;

    localparam int MAX_ROUNDS       = 8;
    localparam int SUBKEY_DEPTH     = 128;
    localparam int TABLE_ROUND_CAP  = (SUBKEY_DEPTH - 9) / 13;
    localparam int KEYS_PER_ROUND   = 13;
    localparam int STAGES_PER_ROUND = 4;
    localparam int NUM_STAGES       = 2 + MAX_ROUNDS * STAGES_PER_ROUND;
    localparam int KEY_IDX_W        = $clog2(SUBKEY_DEPTH);

    localparam logic OP_KEY_WRITE = 1'b0;
    localparam logic OP_ENCRYPT   = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [6:0]  key_index;
        logic [31:0] key_word;
        logic [31:0] block_in_w0;
        logic [31:0] block_in_w1;
        logic [31:0] block_in_w2;
        logic [31:0] block_in_w3;
    } in_t;

    typedef struct packed {
        logic [31:0] block_out_w0;
        logic [31:0] block_out_w1;
        logic [31:0] block_out_w2;
        logic [31:0] block_out_w3;
    } out_t;

    typedef struct packed {
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] p1;
        logic [31:0] p2;
    } pipe_t;

    // rotate a 31-bit value left by s mod 31
    function automatic logic [30:0] rot31(input logic [30:0] v, input logic [4:0] s);
        logic [4:0]  sm;
        logic [61:0] t;
        sm = (s == 5'd31) ? 5'd0 : s;
        t  = {v, v} << sm;
        return t[61:31];
    endfunction

    // one rotation of a chain: even steps keep bit 0, odd steps keep bit 31
    function automatic logic [31:0] chain_rot(input logic [31:0] x, input logic [31:0] sel,
                                              input int i);
        logic [4:0] s;
        case (i)
            0:       s = sel[4:0];
            1:       s = sel[9:5];
            2:       s = sel[14:10];
            3:       s = sel[19:15];
            4:       s = {1'b0, sel[23:20]};
            5:       s = {1'b0, sel[27:24]};
            default: s = {1'b0, sel[31:28]};
        endcase
        if (i % 2 == 1) return {x[31], rot31(x[30:0], s)};
        else            return {rot31(x[31:1], s), x[0]};
    endfunction

    function automatic pipe_t rot128(input pipe_t b, input logic [6:0] amount);
        logic [63:0]  lo;
        logic [63:0]  hi;
        logic [63:0]  sw;
        logic [127:0] tlo;
        logic [127:0] thi;
        pipe_t        r;
        lo = {b.w1, b.w0};
        hi = {b.w3, b.w2};
        if (amount[6]) begin
            sw = lo;
            lo = hi;
            hi = sw;
        end
        tlo  = {lo, hi} << amount[5:0];
        thi  = {hi, lo} << amount[5:0];
        r    = b;
        r.w0 = tlo[95:64];
        r.w1 = tlo[127:96];
        r.w2 = thi[95:64];
        r.w3 = thi[127:96];
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/akelarre_block_encrypt.sv]
// pipelined 128-bit block encryptor with loadable subkey table
//
//  channel  ports                       carries
//  s_       s_valid s_ready s_data      subkey write or plaintext block
//  m_       m_valid m_ready m_data      ciphertext block
//  cfg_     cfg_wr_en cfg_wr_data       round count
//
// one block enters per cycle unless m_ready back-pressure stalls; it passes
// the input stage, four stages per round for all eight rounds and the output
// stage; rounds past the configured count (clamped 1..8) pass data unchanged
// a subkey write waits until the pipeline is empty; stalls collapse bubbles
// stage by stage; reset clears valid bits and sets the round count to 4
`timescale 1ns / 1ps
`default_nettype none

module akelarre_block_encrypt (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire akl_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output akl_pkg::out_t      m_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [3:0]    cfg_wr_data
);

    localparam int NS = akl_pkg::NUM_STAGES;

    logic [31:0]    table_reg [akl_pkg::SUBKEY_DEPTH];
    logic [3:0]     round_count_reg;
    logic [3:0]     n_eff;
    logic [7:0]     key_limit;
    akl_pkg::pipe_t pipe_reg  [NS];
    akl_pkg::pipe_t pipe_next [NS];
    logic [NS-1:0]  vld_reg;
    logic [NS:0]    free;
    logic           busy;
    logic           enc_take;
    logic           key_take;
    logic [31:0]    ok_key [5];

    always_comb begin
        n_eff = round_count_reg;
        if (n_eff < 4'd1) n_eff = 4'd1;
        if (n_eff > 4'(akl_pkg::MAX_ROUNDS)) n_eff = 4'(akl_pkg::MAX_ROUNDS);
        if (n_eff > 4'(akl_pkg::TABLE_ROUND_CAP)) n_eff = 4'(akl_pkg::TABLE_ROUND_CAP);
        key_limit = 8'd9 + 8'd13 * {4'd0, n_eff};
    end

    // stage k can take new data when empty or when its item moves on
    always_comb begin
        free[NS] = m_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            free[k] = !vld_reg[k] || free[k+1];
        end
    end

    assign busy     = |vld_reg;
    assign s_ready  = (s_data.operation == akl_pkg::OP_ENCRYPT) ? free[0] : !busy;
    assign enc_take = s_valid && s_ready && (s_data.operation == akl_pkg::OP_ENCRYPT);
    assign key_take = s_valid && s_ready && (s_data.operation == akl_pkg::OP_KEY_WRITE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_count_reg <= 4'd4;
        end else if (cfg_wr_en) begin
            round_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_take && ({1'b0, s_data.key_index} < key_limit)) begin
            table_reg[s_data.key_index] <= s_data.key_word;
        end
    end

    // input transformation
    always_comb begin
        pipe_next[0].w0 = s_data.block_in_w0 + table_reg[0];
        pipe_next[0].w1 = s_data.block_in_w1 ^ table_reg[1];
        pipe_next[0].w2 = s_data.block_in_w2 ^ table_reg[2];
        pipe_next[0].w3 = s_data.block_in_w3 + table_reg[3];
        pipe_next[0].p1 = '0;
        pipe_next[0].p2 = '0;
    end

    for (genvar k = 1; k < NS - 1; k++) begin : g_round
        localparam int R  = (k - 1) / akl_pkg::STAGES_PER_ROUND;
        localparam int PH = (k - 1) % akl_pkg::STAGES_PER_ROUND;
        localparam int B  = 4 + akl_pkg::KEYS_PER_ROUND * R;

        always_comb begin
            akl_pkg::pipe_t d;
            logic [31:0]    x;
            d = pipe_reg[k-1];
            x = '0;
            if (4'(R) < n_eff) begin
                if (PH == 0) begin
                    d    = akl_pkg::rot128(d, table_reg[B][6:0]);
                    d.p1 = d.w0 ^ d.w2;
                    d.p2 = d.w1 ^ d.w3;
                    x    = d.p2;
                    for (int i = 0; i < 3; i++) begin
                        x = akl_pkg::chain_rot(x, d.p1, i) + table_reg[B + 1 + i];
                    end
                    d.p2 = x;
                end else if (PH == 1) begin
                    x = d.p2;
                    for (int i = 3; i < 7; i++) begin
                        x = akl_pkg::chain_rot(x, d.p1, i);
                        if (i < 6) x = x + table_reg[B + 1 + i];
                    end
                    d.p2 = x;
                end else if (PH == 2) begin
                    x = d.p1;
                    for (int i = 0; i < 4; i++) begin
                        x = akl_pkg::chain_rot(x, d.p2, i) + table_reg[B + 7 + i];
                    end
                    d.p1 = x;
                end else begin
                    x = d.p1;
                    for (int i = 4; i < 7; i++) begin
                        x = akl_pkg::chain_rot(x, d.p2, i);
                        if (i < 6) x = x + table_reg[B + 7 + i];
                    end
                    d.p1 = x;
                    d.w0 = d.w0 ^ d.p2;
                    d.w1 = d.w1 ^ d.p1;
                    d.w2 = d.w2 ^ d.p2;
                    d.w3 = d.w3 ^ d.p1;
                end
            end
            pipe_next[k] = d;
        end
    end

    // output transformation keys sit after the last round in use
    always_comb begin
        for (int j = 0; j < 5; j++) ok_key[j] = table_reg[4 + 13 * akl_pkg::MAX_ROUNDS + j];
        for (int r = 1; r < akl_pkg::MAX_ROUNDS; r++) begin
            if (n_eff == 4'(r)) begin
                for (int j = 0; j < 5; j++) ok_key[j] = table_reg[4 + 13 * r + j];
            end
        end
    end

    always_comb begin
        akl_pkg::pipe_t d;
        d    = akl_pkg::rot128(pipe_reg[NS-2], ok_key[0][6:0]);
        d.w0 = d.w0 + ok_key[1];
        d.w1 = d.w1 ^ ok_key[2];
        d.w2 = d.w2 ^ ok_key[3];
        d.w3 = d.w3 + ok_key[4];
        pipe_next[NS-1] = d;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (free[0]) vld_reg[0] <= enc_take;
            for (int k = 1; k < NS; k++) begin
                if (free[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (free[0] && enc_take) pipe_reg[0] <= pipe_next[0];
        for (int k = 1; k < NS; k++) begin
            if (free[k] && vld_reg[k-1]) pipe_reg[k] <= pipe_next[k];
        end
    end

    assign m_valid             = vld_reg[NS-1];
    assign m_data.block_out_w0 = pipe_reg[NS-1].w0;
    assign m_data.block_out_w1 = pipe_reg[NS-1].w1;
    assign m_data.block_out_w2 = pipe_reg[NS-1].w2;
    assign m_data.block_out_w3 = pipe_reg[NS-1].w3;

endmodule

`default_nettype wire
